>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the unfilter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define PU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pngunf_pkg.sv
// Package: types, constants and helper functions of the PNG unfilter block
`default_nettype none

package pngunf_pkg;

	localparam int LINE_BYTES   = 8192;
	localparam int LINE_AW      = $clog2(LINE_BYTES);
	localparam int COL_W        = 13;
	localparam int ROW_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam logic [COL_W-1:0] COLUMN_LIMIT = 13'd8191;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_PIXELS = 2'd0,
		CFG_IMAGE_ROWS = 2'd1,
		CFG_BPP        = 2'd2
	} cfg_idx_t;

	// one sample (or error) moving from the accept stage to the compute stage
	typedef struct packed {
		logic             err;
		logic [7:0]       sample;
		logic [COL_W-1:0] col;
		filt_t            filt;
		logic             top_row;
		logic             first;
		logic             row_end;
		logic             image_end;
		logic [1:0]       bpp;
	} s1_t;

	function automatic logic [7:0] sel_byte(input logic [23:0] w, input logic [1:0] bpp);
		logic [7:0] r;
		case (bpp)
			2'd2:    r = w[15:8];
			2'd3:    r = w[23:16];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [8:0] pa, pb, pc, ab, cc;
		logic [7:0] r;
		pa = (b > c) ? {1'b0, b - c} : {1'b0, c - b};
		pb = (a > c) ? {1'b0, a - c} : {1'b0, c - a};
		ab = {1'b0, a} + {1'b0, b};
		cc = {c, 1'b0};
		pc = (ab > cc) ? ab - cc : cc - ab;
		if (pa <= pb && pa <= pc)
			r = a;
		else if (pb <= pc)
			r = b;
		else
			r = c;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pngunf_in_if.sv
// Interface: filtered byte stream channel
`default_nettype none

interface pngunf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       image_start;

	modport source (output valid, output stream_byte, output image_start, input ready);
	modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pngunf_out_if.sv
// Interface: reconstructed byte channel
`default_nettype none

interface pngunf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       image_end;
	logic       bad_filter;

	modport source (output valid, output pixel_byte, output row_end, output image_end,
		output bad_filter, input ready);
	modport sink   (input valid, input pixel_byte, input row_end, input image_end,
		input bad_filter, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pngunf_cfg_if.sv
// Interface: configuration register write channel
`default_nettype none

interface pngunf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pngunf_pkg::CFG_IDX_W-1:0]    index;
	logic [pngunf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/png_scanline_unfilter_core.sv
// Top level: PNG scanline unfilter for 8-bit samples with a one-row line buffer
// A sample byte's result is computed in stage 1, then offered from the output register;
//   filter-type bytes give no result, a bad type gives one error.
// Throughput: 1 input byte per cycle unless output stalls, via split RAM read/write ports.
// Reset: control, position and config registers clear at once (config to 1s); the line RAM
//   is not cleared, the first row of every image reads its upper row as zero.
`default_nettype none

`include "assert_macros.svh"

module png_scanline_unfilter_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pngunf_in_if.sink    stream,
	pngunf_out_if.source pixels,
	pngunf_cfg_if.sink   cfg
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes must land only while idle, a rule
	// the block does not enforce; the rest of it reads them directly.
	// ------------------------------------------------------------------
	logic [11:0] row_pixels_q;
	logic [15:0] image_rows_q;
	logic [1:0]  bpp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= 12'd1;
			image_rows_q <= 16'd1;
			bpp_q        <= 2'd1;
		end else if (cfg.valid) begin
			case (pngunf_pkg::cfg_idx_t'(cfg.index))
				pngunf_pkg::CFG_ROW_PIXELS: row_pixels_q <= cfg.data[11:0];
				pngunf_pkg::CFG_IMAGE_ROWS: image_rows_q <= cfg.data[15:0];
				pngunf_pkg::CFG_BPP:        bpp_q        <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// zero means one; row length saturates at the column counter's limit
	logic [1:0]                   bpp_eff;
	logic [15:0]                  rows_eff;
	logic [11:0]                  rp_eff;
	logic [13:0]                  row_prod;
	logic [pngunf_pkg::COL_W-1:0] row_len;

	always_comb begin
		bpp_eff  = (bpp_q == 2'd0) ? 2'd1 : bpp_q;
		rows_eff = (image_rows_q == 16'd0) ? 16'd1 : image_rows_q;
		rp_eff   = (row_pixels_q == 12'd0) ? 12'd1 : row_pixels_q;
		row_prod = {2'b00, rp_eff} * {12'd0, bpp_eff};
		row_len  = (row_prod > {1'b0, pngunf_pkg::COLUMN_LIMIT}) ? pngunf_pkg::COLUMN_LIMIT
			: row_prod[pngunf_pkg::COL_W-1:0];
	end

	// ------------------------------------------------------------------
	// Handshake. Stage 1 holds one item; the output register parts it
	// from the sink so a new byte transfers while a result waits.
	// ------------------------------------------------------------------
	logic            s1_valid_s1;
	pngunf_pkg::s1_t s1_s1;
	logic            out_valid_q;
	logic            s1_adv;
	logic            in_xfer;

	assign s1_adv       = !out_valid_q || pixels.ready;
	assign stream.ready = !s1_valid_s1 || s1_adv;
	assign in_xfer      = stream.valid && stream.ready;

	// ------------------------------------------------------------------
	// Accept stage: position tracking, filter type decode, RAM read issue.
	// ------------------------------------------------------------------
	logic [pngunf_pkg::COL_W-1:0] col_q, col_nx;
	logic [pngunf_pkg::ROW_W-1:0] row_q, row_nx;
	pngunf_pkg::filt_t            filt_q, filt_nx;
	logic                         await_q, await_nx;
	logic                         halt_q, halt_nx;
	logic                         push;
	pngunf_pkg::s1_t              push_item;
	logic [pngunf_pkg::COL_W:0]   col_inc;
	logic [pngunf_pkg::ROW_W:0]   row_inc;

	always_comb begin
		col_nx    = col_q;
		row_nx    = row_q;
		filt_nx   = filt_q;
		await_nx  = await_q;
		halt_nx   = halt_q;
		push      = 1'b0;
		push_item = '0;
		col_inc   = '0;
		row_inc   = '0;
		if (in_xfer) begin
			// start flag wipes position and cancels a halt
			if (stream.image_start) begin
				col_nx   = '0;
				row_nx   = '0;
				await_nx = 1'b1;
				halt_nx  = 1'b0;
			end
			if (!halt_nx) begin
				if (await_nx) begin
					if (stream.stream_byte > 8'(pngunf_pkg::FILT_PAETH)) begin
						push          = 1'b1;
						push_item.err = 1'b1;
						halt_nx       = 1'b1;
					end else begin
						filt_nx  = pngunf_pkg::filt_t'(stream.stream_byte[2:0]);
						await_nx = 1'b0;
						col_nx   = '0;
					end
				end else begin
					push                = 1'b1;
					push_item.sample    = stream.stream_byte;
					push_item.col       = col_nx;
					push_item.filt      = filt_nx;
					push_item.top_row   = (row_nx == '0);
					push_item.first     = (col_nx == '0);
					push_item.bpp       = bpp_eff;
					col_inc             = {1'b0, col_nx} + 1'b1;
					row_inc             = {1'b0, row_nx} + 1'b1;
					if (col_inc >= {1'b0, row_len}) begin
						push_item.row_end = 1'b1;
						col_nx            = '0;
						await_nx          = 1'b1;
						if (row_inc >= {1'b0, rows_eff}) begin
							push_item.image_end = 1'b1;
							halt_nx             = 1'b1;
							row_nx              = '0;
						end else begin
							row_nx = row_inc[pngunf_pkg::ROW_W-1:0];
						end
					end else begin
						col_nx = col_inc[pngunf_pkg::COL_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			filt_q  <= pngunf_pkg::FILT_NONE;
			await_q <= 1'b1;
			halt_q  <= 1'b0;
		end else begin
			col_q   <= col_nx;
			row_q   <= row_nx;
			filt_q  <= filt_nx;
			await_q <= await_nx;
			halt_q  <= halt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			s1_valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && push)
			s1_s1 <= push_item;
	end

	// ------------------------------------------------------------------
	// Line RAM. Read issued on the accept edge, held while stage 1 stalls
	// (read enable only on a sample push). A column is written back by
	// stage 1 before the next row can read it: a type byte always sits
	// between two rows, so no forwarding path is needed.
	// ------------------------------------------------------------------
	logic                           ram_re;
	logic                           ram_we;
	logic [pngunf_pkg::LINE_AW-1:0] ram_raddr;
	logic [7:0]                     ram_rdata;
	logic [7:0]                     x_val;
	logic                           s1_in_line;
	logic                           s1_commit;

	assign ram_re     = push && !push_item.err && (32'(push_item.col) < pngunf_pkg::LINE_BYTES);
	assign ram_raddr  = pngunf_pkg::LINE_AW'(push_item.col);
	assign s1_in_line = 32'(s1_s1.col) < pngunf_pkg::LINE_BYTES;
	assign s1_commit  = s1_valid_s1 && s1_adv;
	assign ram_we     = s1_commit && !s1_s1.err && s1_in_line;

	pngunf_ram #(
		.WIDTH (8),
		.DEPTH (pngunf_pkg::LINE_BYTES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pngunf_pkg::LINE_AW'(s1_s1.col)),
		.wdata (x_val),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: prediction and reconstruction. Left and upper-left history
	// shift in here; the first byte of a row sees them as zero.
	// ------------------------------------------------------------------
	logic [23:0] left_q, upleft_q;
	logic [23:0] left_eff, upleft_eff;
	logic [7:0]  a_val, b_val, c_val, pred;
	logic [8:0]  ab_sum;

	always_comb begin
		left_eff   = s1_s1.first ? 24'd0 : left_q;
		upleft_eff = s1_s1.first ? 24'd0 : upleft_q;
		a_val      = pngunf_pkg::sel_byte(left_eff, s1_s1.bpp);
		c_val      = pngunf_pkg::sel_byte(upleft_eff, s1_s1.bpp);
		b_val      = (s1_s1.top_row || !s1_in_line) ? 8'd0 : ram_rdata;
		ab_sum     = {1'b0, a_val} + {1'b0, b_val};
		case (s1_s1.filt)
			pngunf_pkg::FILT_SUB:   pred = a_val;
			pngunf_pkg::FILT_UP:    pred = b_val;
			pngunf_pkg::FILT_AVG:   pred = ab_sum[8:1];
			pngunf_pkg::FILT_PAETH: pred = pngunf_pkg::paeth(a_val, b_val, c_val);
			default:                pred = 8'd0;
		endcase
		x_val = s1_s1.sample + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_commit && !s1_s1.err) begin
			left_q   <= {left_eff[15:0], x_val};
			upleft_q <= {upleft_eff[15:0], b_val};
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [7:0] pix_q;
	logic       row_end_q, image_end_q, bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_commit) begin
			pix_q       <= s1_s1.err ? 8'd0 : x_val;
			row_end_q   <= s1_s1.row_end;
			image_end_q <= s1_s1.image_end;
			bad_q       <= s1_s1.err;
		end
	end

	assign pixels.valid      = out_valid_q;
	assign pixels.pixel_byte = pix_q;
	assign pixels.row_end    = row_end_q;
	assign pixels.image_end  = image_end_q;
	assign pixels.bad_filter = bad_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`PU_ASSERT(a_no_take_on_stall, !(s1_valid_s1 && !s1_adv && stream.ready),
		"input taken while stage 1 is stalled")
	`PU_ASSERT(a_err_clean, !(out_valid_q && bad_q && (pix_q != 8'd0 || row_end_q)),
		"error result carries data or row mark")
	`PU_ASSERT(a_img_end_row_end, !(out_valid_q && image_end_q && !row_end_q),
		"image end without row end")
	`PU_ASSERT_NEXT(a_halt_after_end, s1_commit && (s1_s1.image_end || s1_s1.err),
		halt_q || $past(in_xfer), "block not halted after image end or error")

endmodule

`default_nettype wire

>>> rtl/core/pngunf_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module pngunf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
